### rtl/core/idhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package idhs_pkg;

	localparam int ID_W   = 32;
	localparam int TIME_W = 24;
	localparam int BYTE_W = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [BYTE_W-1:0] LEAD_ID        = 8'h00;
	localparam logic [BYTE_W-1:0] LEAD_FIRST_HS  = 8'h01;
	localparam logic [BYTE_W-1:0] LEAD_THIRD_HS  = 8'h03;
	localparam logic [BYTE_W-1:0] FRAME_LEN_OK   = 8'h05;

	typedef enum logic {
		OP_ID_CHANNEL = 1'b0,
		OP_HS_CHANNEL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SEND_NONE   = 2'd0,
		SEND_STATUS = 2'd1,
		SEND_REPLY  = 2'd2
	} send_kind_t;

	typedef enum logic [2:0] {
		ST_NONE       = 3'd0,
		ST_SUCCESS    = 3'd1,
		ST_ID_FORMAT  = 3'd2,
		ST_OTHER_USER = 3'd3,
		ST_TIME_MISMATCH = 3'd4
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEVICE_BONDED = 2'd0,
		CFG_STORED_USER_ID = 2'd1,
		CFG_WHITELIST_ADV = 2'd2
	} cfg_index_t;

endpackage

`default_nettype wire

### rtl/core/idhs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface idhs_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [idhs_pkg::BYTE_W-1:0] frame_length;
	logic [idhs_pkg::BYTE_W-1:0] byte0;
	logic [idhs_pkg::BYTE_W-1:0] byte1;
	logic [idhs_pkg::BYTE_W-1:0] byte2;
	logic [idhs_pkg::BYTE_W-1:0] byte3;
	logic [idhs_pkg::BYTE_W-1:0] byte4;
	logic [idhs_pkg::BYTE_W-1:0] random_byte;

	modport source (
		output valid, op, frame_length, byte0, byte1, byte2, byte3, byte4, random_byte,
		input  ready
	);
	modport sink (
		input  valid, op, frame_length, byte0, byte1, byte2, byte3, byte4, random_byte,
		output ready
	);
endinterface

interface idhs_rsp_if;
	logic                        valid;
	logic                        ready;
	idhs_pkg::send_kind_t        send_kind;
	idhs_pkg::status_t           status_code;
	logic [idhs_pkg::BYTE_W-1:0] reply_time0;
	logic [idhs_pkg::BYTE_W-1:0] reply_time1;
	logic [idhs_pkg::BYTE_W-1:0] reply_time2;
	logic [idhs_pkg::BYTE_W-1:0] reply_mask;
	logic                        drop_link;
	logic                        id_accepted;
	logic                        id_differs;
	logic                        link_ready;
	logic [idhs_pkg::ID_W-1:0]   current_user_id;

	modport source (
		output valid, send_kind, status_code, reply_time0, reply_time1, reply_time2,
			reply_mask, drop_link, id_accepted, id_differs, link_ready, current_user_id,
		input  ready
	);
	modport sink (
		input  valid, send_kind, status_code, reply_time0, reply_time1, reply_time2,
			reply_mask, drop_link, id_accepted, id_differs, link_ready, current_user_id,
		output ready
	);
endinterface

interface idhs_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [idhs_pkg::CFG_INDEX_W-1:0] index;
	logic [idhs_pkg::CFG_DATA_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/id_check_and_handshake.sv
`timescale 1ns / 1ps
`default_nettype none

// Checks one received five-byte frame per request: ID frames against the bound user ID under
// the bonded and whitelist modes, first handshake frames answered with a re-masked time, third
// handshake frames compared with the stored time. One request can be accepted every cycle unless
// the input register is full and cannot pass its request on; its result moves from the input
// register through the single compare-and-XOR stage into the result register and is offered
// until taken. A waiting result stalls the input only once the input register is also full.
// Configuration writes are held off while a request sits in the input register and should only
// be issued while no request is in flight; indexes beyond two are ignored.
module id_check_and_handshake (
	input  wire logic clk,
	input  wire logic arst_n,
	idhs_req_if.sink   req,
	idhs_rsp_if.source rsp,
	idhs_cfg_if.sink   cfg
);
	import idhs_pkg::*;

	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] len_s1;
	logic [BYTE_W-1:0] lead_s1;
	logic [BYTE_W-1:0] b1_s1;
	logic [BYTE_W-1:0] b2_s1;
	logic [BYTE_W-1:0] b3_s1;
	logic [BYTE_W-1:0] b4_s1;
	logic [BYTE_W-1:0] rnd_s1;

	logic              bonded_q;
	logic [ID_W-1:0]   received_id_q;
	logic [ID_W-1:0]   user_id_q;
	logic              whitelist_q;
	logic              id_rx_flag_q;
	logic              id_chg_flag_q;
	logic              connected_q;
	logic [TIME_W-1:0] first_time_q;

	logic              out_valid_q;
	send_kind_t        kind_q;
	status_t           status_q;
	logic [BYTE_W-1:0] r0_q;
	logic [BYTE_W-1:0] r1_q;
	logic [BYTE_W-1:0] r2_q;
	logic [BYTE_W-1:0] rm_q;
	logic              drop_q;

	logic              advance;
	logic              fire;

	send_kind_t        kind_d;
	status_t           status_d;
	logic [BYTE_W-1:0] r0_d;
	logic [BYTE_W-1:0] r1_d;
	logic [BYTE_W-1:0] r2_d;
	logic [BYTE_W-1:0] rm_d;
	logic              drop_d;
	logic [ID_W-1:0]   received_id_d;
	logic [ID_W-1:0]   user_id_d;
	logic              whitelist_d;
	logic              id_rx_flag_d;
	logic              id_chg_flag_d;
	logic              connected_d;
	logic [TIME_W-1:0] first_time_d;
	logic [TIME_W-1:0] unmasked_time;
	logic [ID_W-1:0]   frame_id;
	logic              len_ok;

	assign advance   = !out_valid_q || rsp.ready;
	assign fire      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.op;
			len_s1  <= req.frame_length;
			lead_s1 <= req.byte0;
			b1_s1   <= req.byte1;
			b2_s1   <= req.byte2;
			b3_s1   <= req.byte3;
			b4_s1   <= req.byte4;
			rnd_s1  <= req.random_byte;
		end
	end

	assign unmasked_time = {b3_s1 ^ b4_s1, b2_s1 ^ b4_s1, b1_s1 ^ b4_s1};
	assign frame_id      = {b4_s1, b3_s1, b2_s1, b1_s1};
	assign len_ok        = (len_s1 == FRAME_LEN_OK);

	always_comb begin
		kind_d        = SEND_NONE;
		status_d      = ST_NONE;
		r0_d          = '0;
		r1_d          = '0;
		r2_d          = '0;
		rm_d          = '0;
		drop_d        = 1'b0;
		received_id_d = received_id_q;
		user_id_d     = user_id_q;
		whitelist_d   = whitelist_q;
		id_rx_flag_d  = id_rx_flag_q;
		id_chg_flag_d = id_chg_flag_q;
		connected_d   = connected_q;
		first_time_d  = first_time_q;
		if (op_s1 == OP_ID_CHANNEL) begin
			id_rx_flag_d = 1'b0;
			first_time_d = '0;
			if (lead_s1 == LEAD_ID && len_ok) begin
				received_id_d = frame_id;
				if (bonded_q) begin
					if (whitelist_q) begin
						if (frame_id == user_id_q) begin
							id_rx_flag_d  = 1'b1;
							id_chg_flag_d = 1'b0;
						end else begin
							kind_d   = SEND_STATUS;
							status_d = ST_OTHER_USER;
							drop_d   = 1'b1;
						end
					end else begin
						id_rx_flag_d  = 1'b1;
						id_chg_flag_d = (frame_id != user_id_q);
					end
				end else begin
					id_rx_flag_d  = 1'b1;
					id_chg_flag_d = 1'b1;
				end
			end else begin
				kind_d   = SEND_STATUS;
				status_d = ST_ID_FORMAT;
				drop_d   = 1'b1;
			end
		end else if (len_ok) begin
			case (lead_s1)
				LEAD_FIRST_HS: begin
					first_time_d = unmasked_time;
					kind_d       = SEND_REPLY;
					r0_d         = unmasked_time[7:0] ^ rnd_s1;
					r1_d         = unmasked_time[15:8] ^ rnd_s1;
					r2_d         = unmasked_time[23:16] ^ rnd_s1;
					rm_d         = rnd_s1;
				end
				LEAD_THIRD_HS: begin
					kind_d = SEND_STATUS;
					if (unmasked_time == first_time_q) begin
						status_d    = ST_SUCCESS;
						user_id_d   = received_id_q;
						whitelist_d = 1'b1;
						connected_d = 1'b1;
					end else begin
						status_d = ST_TIME_MISMATCH;
						drop_d   = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bonded_q      <= 1'b0;
			received_id_q <= '0;
			user_id_q     <= '0;
			whitelist_q   <= 1'b0;
			id_rx_flag_q  <= 1'b0;
			id_chg_flag_q <= 1'b0;
			connected_q   <= 1'b0;
			first_time_q  <= '0;
		end else if (fire) begin
			received_id_q <= received_id_d;
			user_id_q     <= user_id_d;
			whitelist_q   <= whitelist_d;
			id_rx_flag_q  <= id_rx_flag_d;
			id_chg_flag_q <= id_chg_flag_d;
			connected_q   <= connected_d;
			first_time_q  <= first_time_d;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_DEVICE_BONDED:  bonded_q    <= cfg.data[0];
				CFG_STORED_USER_ID: user_id_q   <= cfg.data[ID_W-1:0];
				CFG_WHITELIST_ADV:  whitelist_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q   <= kind_d;
			status_q <= status_d;
			r0_q     <= r0_d;
			r1_q     <= r1_d;
			r2_q     <= r2_d;
			rm_q     <= rm_d;
			drop_q   <= drop_d;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.send_kind       = kind_q;
	assign rsp.status_code     = status_q;
	assign rsp.reply_time0     = r0_q;
	assign rsp.reply_time1     = r1_q;
	assign rsp.reply_time2     = r2_q;
	assign rsp.reply_mask      = rm_q;
	assign rsp.drop_link       = drop_q;
	assign rsp.id_accepted     = id_rx_flag_q;
	assign rsp.id_differs      = id_chg_flag_q;
	assign rsp.link_ready      = connected_q;
	assign rsp.current_user_id = user_id_q;

	a_status_only_with_status_frame: assert property (
		@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.send_kind != SEND_STATUS |-> rsp.status_code == ST_NONE
	) else $error("status code set without a status frame");

	a_reply_only_with_reply_frame: assert property (
		@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.send_kind != SEND_REPLY |->
			rsp.reply_mask == '0 && rsp.reply_time0 == '0 &&
			rsp.reply_time1 == '0 && rsp.reply_time2 == '0
	) else $error("reply bytes set without a reply frame");

	a_drop_only_on_error: assert property (
		@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.drop_link |->
			rsp.send_kind == SEND_STATUS &&
			(rsp.status_code == ST_ID_FORMAT || rsp.status_code == ST_OTHER_USER ||
			 rsp.status_code == ST_TIME_MISMATCH)
	) else $error("disconnect requested without an error status");

	a_link_rises_on_success: assert property (
		@(posedge clk) disable iff (!arst_n)
		$rose(connected_q) |-> out_valid_q && kind_q == SEND_STATUS && status_q == ST_SUCCESS
	) else $error("link became ready without a successful handshake");

endmodule

`default_nettype wire
